// File: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; every use expects signals named clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define BMHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// implication form: pre in this cycle requires post in the same cycle
`define BMHQ_ASSERT_IMPLY(label, pre, post, msg) \
  `BMHQ_ASSERT(label, (pre) |-> (post), msg)

`endif

// File: design/bmhq_pkg.sv
// types and constants for the binary min-heap queue
// no dependencies; used by every module of the block except bmhq_ram
package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 7;
  localparam int CNT_W = 7;
  localparam int STS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] key;
  } request_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic signed [31:0] removed_key;
    logic signed [31:0] top_key;
    logic               top_valid;
    logic [CNT_W-1:0]   count;
  } result_t;

  // heap memory read address selection
  typedef enum logic [1:0] {
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // heap memory write selection
  typedef enum logic [1:0] {
    WR_NONE,
    WR_KEY,
    WR_UP,
    WR_DOWN
  } wr_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_TEST,
    S_UP_CMP,
    S_DN_KEY,
    S_DN_TEST,
    S_DN_R,
    S_DN_CMP,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             ins_load;
    logic             del_take;
    logic             latch_left;
    rd_sel_t          rd_sel;
    wr_sel_t          wr_sel;
    logic             fin;
    logic [STS_W-1:0] fin_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic no_child;
    logic up_swap;
    logic dn_swap;
  } sts_t;

endpackage

// File: design/bmhq_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/bmhq_ctrl.sv
// sequencing state machine for insert sift-up and delete-min sift-down
// depends on bmhq_pkg (state_t, cmd_t, sts_t, codes)
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            operation,
  input  bmhq_pkg::sts_t  sts,
  output bmhq_pkg::cmd_t  cmd,
  output logic            busy
);

  bmhq_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = bmhq_pkg::RD_LAST;
    cmd.wr_sel     = bmhq_pkg::WR_NONE;
    cmd.fin_status = bmhq_pkg::ST_DONE;
    unique case (state)
      bmhq_pkg::S_IDLE: begin
        if (start) begin
          if (operation == bmhq_pkg::OP_INSERT) begin
            if (sts.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = bmhq_pkg::ST_FULL;
            end else begin
              cmd.ins_load = 1'b1;
              state_next   = bmhq_pkg::S_UP_TEST;
            end
          end else begin
            if (sts.empty) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = bmhq_pkg::ST_EMPTY;
            end else begin
              // fetch the last entry, it becomes the new root
              cmd.rd_sel = bmhq_pkg::RD_LAST;
              state_next = bmhq_pkg::S_DN_KEY;
            end
          end
        end
      end
      bmhq_pkg::S_UP_TEST: begin
        if (sts.at_root) begin
          cmd.wr_sel = bmhq_pkg::WR_KEY;
          state_next = bmhq_pkg::S_FINISH;
        end else begin
          cmd.rd_sel = bmhq_pkg::RD_PARENT;
          state_next = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.wr_sel = bmhq_pkg::WR_UP;
          state_next = bmhq_pkg::S_UP_TEST;
        end else begin
          cmd.wr_sel = bmhq_pkg::WR_KEY;
          state_next = bmhq_pkg::S_FINISH;
        end
      end
      bmhq_pkg::S_DN_KEY: begin
        cmd.del_take = 1'b1;
        state_next   = bmhq_pkg::S_DN_TEST;
      end
      bmhq_pkg::S_DN_TEST: begin
        if (sts.no_child) begin
          cmd.wr_sel = bmhq_pkg::WR_KEY;
          state_next = bmhq_pkg::S_FINISH;
        end else begin
          cmd.rd_sel = bmhq_pkg::RD_LEFT;
          state_next = bmhq_pkg::S_DN_R;
        end
      end
      bmhq_pkg::S_DN_R: begin
        cmd.rd_sel     = bmhq_pkg::RD_RIGHT;
        cmd.latch_left = 1'b1;
        state_next     = bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_CMP: begin
        if (sts.dn_swap) begin
          cmd.wr_sel = bmhq_pkg::WR_DOWN;
          state_next = bmhq_pkg::S_DN_TEST;
        end else begin
          cmd.wr_sel = bmhq_pkg::WR_KEY;
          state_next = bmhq_pkg::S_FINISH;
        end
      end
      bmhq_pkg::S_FINISH: begin
        cmd.fin    = 1'b1;
        state_next = bmhq_pkg::S_IDLE;
      end
      default: begin
        state_next = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != bmhq_pkg::S_IDLE);

endmodule

// File: design/bmhq_dpath.sv
// heap datapath: entry count, moving key, position, root copy, capacity, result
// depends on bmhq_pkg and bmhq_ram
module bmhq_dpath #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bmhq_pkg::request_t              request,
  input  bmhq_pkg::cmd_t                  cmd,
  output bmhq_pkg::sts_t                  sts,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmhq_pkg::CAP_W-1:0]      cfg_data,
  output logic                            result_valid,
  output bmhq_pkg::result_t               result
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > bmhq_pkg::CAP_W) ? CW : bmhq_pkg::CAP_W;

  logic [CW-1:0]                count, pos;
  logic [bmhq_pkg::KEY_W-1:0]   kreg, left_key, removed, root;
  logic [bmhq_pkg::CAP_W-1:0]   cap;
  logic [CW:0]                  pos_x2, pos_x2p1, count_w;
  logic                         has_right, pick_right;
  logic [bmhq_pkg::KEY_W-1:0]   child_key, rd_data, wr_data;
  logic [CW-1:0]                rd_addr;
  logic                         wr_en;
  logic [EW-1:0]                cap_eff;

  // heap store, one-based, position zero unused
  bmhq_ram #(
    .WIDTH(bmhq_pkg::KEY_W),
    .DEPTH(MAX_ENTRIES + 1)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(pos),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // child positions and bounds
  assign pos_x2    = {pos, 1'b0};
  assign pos_x2p1  = {pos, 1'b1};
  assign count_w   = {1'b0, count};
  assign has_right = (pos_x2p1 <= count_w);

  // child choice: left only when strictly smaller than right or when there is no right child
  assign pick_right = has_right && !($signed(left_key) < $signed(rd_data));
  assign child_key  = pick_right ? rd_data : left_key;

  // capacity limited to the built size
  assign cap_eff = (EW'(cap) > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(cap);

  // status to the controller
  always_comb begin
    sts.full     = (EW'(count) >= cap_eff);
    sts.empty    = (count == '0);
    sts.at_root  = (pos == CW'(1));
    sts.no_child = (pos_x2 > count_w);
    sts.up_swap  = ($signed(kreg) < $signed(rd_data));
    sts.dn_swap  = ($signed(child_key) < $signed(kreg));
  end

  // read address
  always_comb begin
    unique case (cmd.rd_sel)
      bmhq_pkg::RD_LAST:   rd_addr = count;
      bmhq_pkg::RD_PARENT: rd_addr = pos >> 1;
      bmhq_pkg::RD_LEFT:   rd_addr = pos_x2[CW-1:0];
      bmhq_pkg::RD_RIGHT:  rd_addr = pos_x2p1[CW-1:0];
      default:             rd_addr = count;
    endcase
  end

  // write data at the current position
  always_comb begin
    wr_en   = 1'b1;
    wr_data = kreg;
    unique case (cmd.wr_sel)
      bmhq_pkg::WR_NONE: wr_en   = 1'b0;
      bmhq_pkg::WR_KEY:  wr_data = kreg;
      bmhq_pkg::WR_UP:   wr_data = rd_data;
      bmhq_pkg::WR_DOWN: wr_data = child_key;
      default:           wr_en   = 1'b0;
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_load) begin
      count <= count + CW'(1);
    end else if (cmd.del_take) begin
      count <= count - CW'(1);
    end
  end

  // position, moving key and latched operands
  always_ff @(posedge clk) begin
    if (cmd.ins_load) begin
      pos     <= count + CW'(1);
      kreg    <= request.key;
      removed <= '0;
    end else if (cmd.del_take) begin
      pos     <= CW'(1);
      kreg    <= rd_data;
      removed <= root;
    end else if (cmd.wr_sel == bmhq_pkg::WR_UP) begin
      pos <= pos >> 1;
    end else if (cmd.wr_sel == bmhq_pkg::WR_DOWN) begin
      pos <= pick_right ? pos_x2p1[CW-1:0] : pos_x2[CW-1:0];
    end
    if (cmd.latch_left) begin
      left_key <= rd_data;
    end
  end

  // copy of the root entry
  always_ff @(posedge clk) begin
    if (wr_en && (pos == CW'(1))) begin
      root <= wr_data;
    end
  end

  // capacity register, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= bmhq_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result.status      <= cmd.fin_status;
      result.removed_key <= (cmd.fin_status == bmhq_pkg::ST_DONE) ? removed : '0;
      result.top_key     <= (count != '0) ? root : '0;
      result.top_valid   <= (count != '0);
      result.count       <= bmhq_pkg::CNT_W'(count);
    end
  end

endmodule

// File: design/binary_min_heap_queue_core.sv
// top level of the binary min-heap priority queue
// depends on bmhq_pkg, bmhq_ctrl, bmhq_dpath (and bmhq_ram below it)
//
// Usage
//   Request channel: drive request (operation, key) with start high; the
//   transfer happens at a rising edge with start high and busy low.
//   Result channel: one result per request, on result for exactly one cycle
//   with result_valid high. The receiver cannot stall it.
//   Configuration: cfg_data is written into the capacity register at an edge
//   with cfg_valid and cfg_ready high; cfg_ready is always high.
//   Sequencing: a refused request (full or empty) shows its result the cycle
//   after the transfer and busy stays low. An insert moves its key up one
//   level per parent read and compare until it reaches the root or stops
//   below it; a delete-min moves the last entry down from the root one
//   level per left read, right read and compare until it ends at a leaf or
//   stops above one. Each ends with a finish step. The single read port of
//   the heap memory, with its registered read, sets the steps per level.
//   The next request can be taken in the cycle its predecessor's result
//   shows.
//   Reset: the heap is emptied (count zero), capacity returns to 64.
module binary_min_heap_queue_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bmhq_pkg::request_t         request,
  output logic                       result_valid,
  output bmhq_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bmhq_pkg::CAP_W-1:0] cfg_data
);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  // sequencing
  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(request.operation),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // storage and arithmetic
  bmhq_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

// File: design/bmhq_checker.sv
// port-level checks for the heap queue, attached to the top level by bind
// depends on bmhq_pkg and assert_macros.svh
`include "assert_macros.svh"

module bmhq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid,
  input bmhq_pkg::result_t          result
);

  logic refused;

  // result of a refused request
  assign refused = result_valid && (result.status != bmhq_pkg::ST_DONE);

  // an accepted request either finishes at once or keeps the block busy
  `BMHQ_ASSERT(a_accept_progress, (start && !busy) |=> (result_valid || busy), "request lost")

  // minimum present exactly when the heap holds keys
  `BMHQ_ASSERT_IMPLY(a_top_valid, result_valid, result.top_valid == (result.count != '0), "top_valid")

  // empty heap reports a zero minimum
  `BMHQ_ASSERT_IMPLY(a_top_zero, result_valid && !result.top_valid, result.top_key == '0, "top_key")

  // refused requests remove nothing
  `BMHQ_ASSERT_IMPLY(a_refused_zero, refused, result.removed_key == '0, "removed_key on refusal")

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result)
);
